[rtl/bpl_pkg.sv]
// Shared widths, register indexes and controller/datapath interface types.
package bpl_pkg;

	// Default bitmap word width
	localparam int DEF_WORD_BITS = 64;

	// Field widths
	localparam int IN_WORD_W  = 64;
	localparam int IDX_W      = 26;
	localparam int POS_W      = 32;
	localparam int VBC_W      = 33;
	localparam int WCNT_W     = 27;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 32;

	// Configuration port
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 33;
	localparam logic [CFG_ADDR_W-1:0] CFG_VALID_BIT_COUNT = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_WORD_COUNT      = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;  // capture input beat
		logic prep;  // compute base position and range check
		logic mask;  // build the qualifying bit mask
		logic pop;   // emit lowest qualifying bit into output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic any;   // qualifying mask being built is nonzero
		logic last;  // lowest pending bit is the only one left
	} status_t;

endpackage

[rtl/bpl_ctrl.sv]
// Sequencing controller: input handshake, emit loop, output valid.
module bpl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output bpl_pkg::cmd_t     cmd,
	input  bpl_pkg::status_t  st
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_MASK = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;

	// Commands
	always_comb begin
		cmd      = '0;
		cmd.load = s_tvalid && s_tready;
		cmd.prep = (state_q == ST_PREP);
		cmd.mask = (state_q == ST_MASK);
		cmd.pop  = (state_q == ST_EMIT) && slot_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = ST_MASK;
			end
			ST_MASK: begin
				state_d = st.any ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (cmd.pop && st.last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.pop)       out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	// The PREP and MASK setup states follow every accepted beat
	a_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
		else $error("input taken during setup");

	// A popped position always shows up on the output
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> m_tvalid)
		else $error("popped position not presented");

	// Empty word returns to idle without emitting
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MASK && !st.any) |=> (s_tready && !cmd.pop))
		else $error("empty word did not return to idle");
`endif

endmodule

[rtl/bpl_datapath.sv]
// Datapath: config registers, base/range calc, qualifying mask, lowest-bit emit.
module bpl_datapath #(
	parameter int WORD_BITS = bpl_pkg::DEF_WORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bpl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [bpl_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [bpl_pkg::S_TDATA_W-1:0]       s_tdata,
	output logic [bpl_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                m_tlast,
	input  bpl_pkg::cmd_t                       cmd,
	output bpl_pkg::status_t                    st
);

	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam int POS_W = bpl_pkg::POS_W;
	localparam int VBC_W = bpl_pkg::VBC_W;
	localparam int IDX_W = bpl_pkg::IDX_W;

	logic [VBC_W-1:0]            vbc_q;
	logic [bpl_pkg::WCNT_W-1:0]  wcnt_q;
	logic [WORD_BITS-1:0]        word_q;
	logic [IDX_W-1:0]            idx_q;
	logic [POS_W-1:0]            base_q;
	logic                        in_range_q;
	logic [WORD_BITS-1:0]        pend_q;
	logic [POS_W-1:0]            pos_q;
	logic                        last_q;

	logic [VBC_W:0]              room;
	logic [CNT_W-1:0]            cnt;
	logic [WORD_BITS-1:0]        thermo;
	logic [WORD_BITS-1:0]        qual;
	logic [WORD_BITS-1:0]        low;
	logic [BIT_W-1:0]            bit_idx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbc_q  <= '0;
			wcnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				bpl_pkg::CFG_VALID_BIT_COUNT: vbc_q  <= cfg_data;
				bpl_pkg::CFG_WORD_COUNT:      wcnt_q <= cfg_data[bpl_pkg::WCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Positions left below the valid bit count, clamped to the word width
	always_comb begin
		room = {1'b0, vbc_q} - {2'b00, base_q};
		if (room[VBC_W])
			cnt = '0;
		else if (room[VBC_W-1:0] >= VBC_W'(WORD_BITS))
			cnt = CNT_W'(WORD_BITS);
		else
			cnt = room[CNT_W-1:0];
		for (int i = 0; i < WORD_BITS; i++)
			thermo[i] = (CNT_W'(i) < cnt);
		qual = word_q & thermo & {WORD_BITS{in_range_q}};
	end

	// Lowest pending bit and its number
	always_comb begin
		low     = pend_q & (~pend_q + WORD_BITS'(1));
		bit_idx = '0;
		for (int i = 0; i < WORD_BITS; i++)
			if (low[i]) bit_idx = bit_idx | BIT_W'(i);
	end

	assign st.any  = |qual;
	assign st.last = ((pend_q & ~low) == '0);

	// Item registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= s_tdata[WORD_BITS-1:0];
			idx_q  <= s_tdata[bpl_pkg::IN_WORD_W +: IDX_W];
		end
		if (cmd.prep) begin
			base_q     <= {{(POS_W-IDX_W){1'b0}}, idx_q} * POS_W'(WORD_BITS);
			in_range_q <= ({1'b0, idx_q} < wcnt_q);
		end
		if (cmd.mask)
			pend_q <= qual;
		else if (cmd.pop)
			pend_q <= pend_q & ~low;
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			pos_q  <= base_q + POS_W'(bit_idx);
			last_q <= st.last;
		end
	end

	assign m_tdata = pos_q;
	assign m_tlast = last_q;

endmodule

[rtl/bitmap_to_position_list_unit.sv]
// Top level: bitmap word to set-bit position list decoder.
//
// Channel  Dir  Beat content
// s_*      in   tdata = word_bits[63:0], word_index[89:64], zero pad to 96
// m_*      out  tdata = position[31:0]; tlast = last_in_word
// cfg_*    in   index 0 valid_bit_count, 1 word_count; write on cfg_we
//
// One word at a time: after accepting a word the unit steps through PREP and
// MASK, then emits the n positions it yields (none for an empty word) before
// taking the next. The lowest-set-bit finder gives one position a cycle unless the output stalls.
// Reset clears the control state and both config registers to zero.
// A stalled output holds its beat; input is still taken once the emit loop ends.
module bitmap_to_position_list_unit #(
	parameter int WORD_BITS = bpl_pkg::DEF_WORD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bpl_pkg::S_TDATA_W-1:0]   s_tdata,   // word_bits, word_index, pad
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bpl_pkg::M_TDATA_W-1:0]   m_tdata,   // position
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [bpl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [bpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bpl_pkg::cmd_t    cmd;
	bpl_pkg::status_t st;

	bpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	bpl_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

[test/bitmap_to_position_list_unit_tb.sv]
// Self-checking testbench for the bitmap word to set-bit position list decoder.
`timescale 1ns / 1ps

module bitmap_to_position_list_unit_tb;

	localparam int WORD_BITS      = bpl_pkg::DEF_WORD_BITS;
	localparam int IN_WORD_W      = bpl_pkg::IN_WORD_W;
	localparam int IDX_W          = bpl_pkg::IDX_W;
	localparam int POS_W          = bpl_pkg::POS_W;
	localparam int VBC_W          = bpl_pkg::VBC_W;
	localparam int WCNT_W         = bpl_pkg::WCNT_W;
	localparam int S_TDATA_W      = bpl_pkg::S_TDATA_W;
	localparam int M_TDATA_W      = bpl_pkg::M_TDATA_W;
	localparam int CFG_ADDR_W     = bpl_pkg::CFG_ADDR_W;
	localparam int CFG_DATA_W     = bpl_pkg::CFG_DATA_W;
	localparam int RST_CYCLES     = 6;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT    = 3000;

	localparam logic [VBC_W-1:0]  VBC_MAX  = 33'h1_0000_0000;
	localparam logic [WCNT_W-1:0] WCNT_MAX = 27'h400_0000;
	localparam logic [IDX_W-1:0]  IDX_MAX  = 26'h3FF_FFFF;
	localparam logic [63:0]       ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]       TOP_BIT  = 64'h8000_0000_0000_0000;

	// One emitted position as seen on the output stream
	typedef struct {
		logic [POS_W-1:0] position;
		logic             last_in_word;
	} pos_beat_t;

	// Directed table rows: a register setting, a word checked by the predictor,
	// a word that must yield nothing, or a word that yields one known position
	typedef enum logic [1:0] {ROW_CONFIG, ROW_WORD, ROW_NONE, ROW_ONE} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [63:0]       bits;
		logic [IDX_W-1:0]  idx;
		logic [POS_W-1:0]  pos;
		logic [VBC_W-1:0]  vbc;
		logic [WCNT_W-1:0] wc;
	} stim_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;
	logic                  cfg_we   = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = bpl_pkg::CFG_VALID_BIT_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor copy of the registers
	logic [VBC_W-1:0]  vbc_q        = '0;
	logic [WCNT_W-1:0] word_count_q = '0;

	pos_beat_t pending_positions[$];
	stim_row_t directed_rows[$];
	pos_beat_t got_beat;
	int        mismatch_count = 0;
	int        stall_cycles   = 0;

	// Idling controls shared with the receiver process
	bit tx_jitter   = 1'b1;
	bit rx_jitter   = 1'b1;
	bit rx_hold_req = 1'b0;
	int rx_hold_left = 0;

	bitmap_to_position_list_unit #(
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		mismatch_count++;
	endtask

	// Append one expected position to the tail of the pending list
	function automatic void queue_position(logic [POS_W-1:0] pos, logic last);
		pos_beat_t beat;
		beat.position     = pos;
		beat.last_in_word = last;
		pending_positions.insert(pending_positions.size(), beat);
	endfunction

	// Expected positions of one accepted word, appended to the pending list
	function automatic void predict_word(logic [63:0] bits, logic [IDX_W-1:0] idx);
		logic [63:0]      base_wide;
		logic [POS_W-1:0] pos;
		int               first;
		if ({1'b0, idx} >= word_count_q)
			return;
		base_wide = 64'(idx) * WORD_BITS;
		first = pending_positions.size();
		for (int b = 0; b < WORD_BITS && b < 64; b++) begin
			if (bits[b]) begin
				pos = base_wide[POS_W-1:0] + POS_W'(b);
				if ({1'b0, pos} >= vbc_q)
					break;
				queue_position(pos, 1'b0);
			end
		end
		if (pending_positions.size() > first)
			pending_positions[pending_positions.size() - 1].last_in_word = 1'b1;
	endfunction

	function automatic void add_word_row(row_kind_t kind, logic [63:0] bits,
			logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos);
		stim_row_t r;
		r = '{kind, bits, idx, pos, '0, '0};
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	function automatic void add_config_row(logic [VBC_W-1:0] vbc, logic [WCNT_W-1:0] wc);
		stim_row_t r;
		r = '{ROW_CONFIG, '0, '0, '0, vbc, wc};
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	// Offer one input beat, with random idle cycles ahead of it
	task automatic drive_word(logic [63:0] bits, logic [IDX_W-1:0] idx);
		while (tx_jitter && $urandom_range(99, 0) < 13) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - IDX_W - IN_WORD_W){1'b0}}, idx, bits};
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
	endtask

	// Stop offering and wait for every pending position
	task automatic drain_positions();
		s_tvalid <= 1'b0;
		while (pending_positions.size() != 0)
			@(posedge clk);
	endtask

	// Idle block: nothing pending and any empty word run out
	task automatic settle();
		drain_positions();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both registers, back to back; word count data may carry junk above its width
	task automatic set_config(logic [VBC_W-1:0] vbc, logic [CFG_DATA_W-1:0] wc_raw);
		cfg_we   <= 1'b1;
		cfg_addr <= bpl_pkg::CFG_VALID_BIT_COUNT;
		cfg_data <= vbc;
		@(posedge clk);
		vbc_q = vbc;
		cfg_addr <= bpl_pkg::CFG_WORD_COUNT;
		cfg_data <= wc_raw;
		@(posedge clk);
		word_count_q = wc_raw[WCNT_W-1:0];
		cfg_we <= 1'b0;
	endtask

	// Random words of mixed density with indices in [idx_lo, idx_hi]
	task automatic run_random(int count, int unsigned idx_lo, int unsigned idx_hi);
		logic [63:0]      bits;
		logic [IDX_W-1:0] idx;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(6, 0))
				0: bits = '0;
				1: bits = ONES;
				2: bits = 64'(1) << $urandom_range(63, 0);
				3: bits = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
				4: bits = {$urandom, $urandom} | {$urandom, $urandom};
				default: bits = {$urandom, $urandom};
			endcase
			idx = IDX_W'($urandom_range(idx_hi, idx_lo));
			drive_word(bits, idx);
			predict_word(bits, idx);
		end
	endtask

	// Receiver: random back-pressure, plus a long hold when asked for
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_left = RX_HOLD_CYCLES;
				rx_hold_req  = 1'b0;
			end
			if (rx_hold_left != 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else begin
				m_tready <= !(rx_jitter && $urandom_range(99, 0) < 13);
			end
		end
	end

	// Output checker: each beat against the oldest pending position
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_positions.size() == 0) begin
				report_mismatch("output beat with nothing pending", '0, 64'(m_tdata));
			end else begin
				got_beat = pending_positions.pop_front();
				if (m_tdata !== got_beat.position)
					report_mismatch("position", 64'(got_beat.position), 64'(m_tdata));
				if (m_tlast !== got_beat.last_in_word)
					report_mismatch("last_in_word", 64'(got_beat.last_in_word),
						64'(m_tlast));
			end
		end
	end

	// Watchdog on cycles with no beat accepted on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t         row;
		logic [WCNT_W-1:0] wc_small;

		// Reset values: nothing is in range yet
		add_word_row(ROW_NONE, ONES, '0, '0);
		add_word_row(ROW_NONE, ONES, IDX_MAX, '0);
		// Widest settings: every position counts
		add_config_row(VBC_MAX, WCNT_MAX);
		add_word_row(ROW_NONE, '0, '0, '0);
		add_word_row(ROW_ONE, 64'h1, '0, 32'd0);
		add_word_row(ROW_ONE, TOP_BIT, 26'd1, 32'd127);
		add_word_row(ROW_ONE, TOP_BIT, IDX_MAX, 32'hFFFF_FFFF);
		add_word_row(ROW_ONE, 64'h1, IDX_MAX, 32'hFFFF_FFC0);
		add_word_row(ROW_WORD, ONES, '0, '0);
		add_word_row(ROW_WORD, ONES, IDX_MAX, '0);
		add_word_row(ROW_WORD, 64'h5555_5555_5555_5555, 26'h2AA_AAAA, '0);
		add_word_row(ROW_WORD, 64'hAAAA_AAAA_AAAA_AAAA, 26'h155_5555, '0);
		add_word_row(ROW_NONE, '0, IDX_MAX, '0);
		// Bit count cuts a word in the middle; words past the count drop out
		add_config_row(33'd100, 27'd3);
		add_word_row(ROW_WORD, ONES, 26'd1, '0);
		add_word_row(ROW_NONE, ONES, 26'd2, '0);
		add_word_row(ROW_NONE, ONES, 26'd3, '0);
		add_word_row(ROW_ONE, TOP_BIT, '0, 32'd63);
		add_word_row(ROW_ONE, 64'h0000_0018_0000_0000, 26'd1, 32'd99);
		// Zero bit count, then zero word count
		add_config_row('0, WCNT_MAX);
		add_word_row(ROW_NONE, ONES, '0, '0);
		add_config_row(VBC_MAX, '0);
		add_word_row(ROW_NONE, ONES, '0, '0);
		// Exactly one word's worth
		add_config_row(33'd64, 27'd1);
		add_word_row(ROW_WORD, ONES, '0, '0);
		add_word_row(ROW_NONE, ONES, 26'd1, '0);

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_CONFIG: begin
					settle();
					set_config(row.vbc, {{(CFG_DATA_W - WCNT_W){1'b0}}, row.wc});
				end
				default: begin
					drive_word(row.bits, row.idx);
					if (row.kind == ROW_ONE)
						queue_position(row.pos, 1'b1);
					else if (row.kind == ROW_WORD)
						predict_word(row.bits, row.idx);
				end
			endcase
		end

		// Full index range, everything in range
		settle();
		set_config(VBC_MAX, {6'b10_1101, WCNT_MAX});
		run_random(40, 0, IDX_MAX);

		// Small bitmap, with a pause until all positions are out
		settle();
		wc_small = WCNT_W'($urandom_range(6, 1));
		set_config(VBC_W'($urandom_range(wc_small * 64 + 32, 0)), {6'b01_0010, wc_small});
		run_random(20, 0, wc_small + 1);
		drain_positions();
		run_random(20, 0, wc_small + 1);

		// No idling; the receiver holds off long enough to stall the input
		settle();
		set_config(VBC_MAX, {6'b0, WCNT_MAX});
		tx_jitter   = 1'b0;
		rx_jitter   = 1'b0;
		rx_hold_req = 1'b1;
		run_random(30, 0, IDX_MAX);
		settle();
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;

		// Top of the index range against a bit count just under the maximum
		set_config(VBC_MAX - VBC_W'($urandom_range(200, 0)), {6'b11_1111, WCNT_MAX});
		run_random(25, IDX_MAX - 3, IDX_MAX);

		// Registers at random over their full width
		settle();
		set_config({1'($urandom_range(1, 0)), $urandom}, CFG_DATA_W'({$urandom, $urandom}));
		run_random(25, 0, IDX_MAX);

		// A few more small bitmaps
		for (int p = 0; p < 3; p++) begin
			settle();
			wc_small = WCNT_W'($urandom_range(8, 1));
			set_config(VBC_W'($urandom_range(wc_small * 64 + 16, 0)), {6'b0, wc_small});
			run_random(10, 0, wc_small + 1);
		end

		drain_positions();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_positions.size() != 0)
			report_mismatch("positions never emitted", 64'(pending_positions.size()), '0);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
